[rtl/name_based_uuid_v3_generator_defines.svh]
// assertion macros for the uuid v3 generator
`ifndef NAME_BASED_UUID_V3_GENERATOR_DEFINES_SVH
`define NAME_BASED_UUID_V3_GENERATOR_DEFINES_SVH
// property must hold on every clock edge outside reset
`define UV3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication: consequent checked in the cycle after the antecedent
`define UV3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/uv3_pkg.sv]
// shared types, constants and functions of the uuid v3 generator
`default_nettype none
package uv3_pkg;
	localparam int unsigned LengthBitsDefault = 33;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 64;
	localparam logic [CfgIdxW-1:0] REG_NS_HIGH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_NS_LOW = 1'b1;

	typedef struct packed {
		logic [7:0] name_byte;
		logic byte_present;
		logic last_item;
	} in_item_t;

	typedef struct packed {
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NS,
		ST_BYTE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} uv3_state_t;

	// datapath commands from the controller
	typedef struct packed {
		logic init;
		logic load_byte;
		logic write_byte;
		logic [1:0] byte_sel;
		logic [3:0] ns_idx;
		logic start_round;
		logic round_en;
		logic chain_add;
	} uv3_cmd_t;

	// byte source for the buffer write
	localparam logic [1:0] SEL_NAME = 2'd0;
	localparam logic [1:0] SEL_NS = 2'd1;
	localparam logic [1:0] SEL_PAD = 2'd2;
	localparam logic [1:0] SEL_LEN = 2'd3;

	typedef struct packed {
		logic [5:0] pos;
		logic round_last;
	} uv3_status_t;

	function automatic logic [31:0] sine_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7; 4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5; 4'd5: s = 5'd9; 4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4; 4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_idx(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction
endpackage
`default_nettype wire

[rtl/uv3_ram.sv]
// generic simple dual-port ram, registered read
`default_nettype none
module uv3_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/uv3_datapath.sv]
// md5 datapath: block buffer, round unit, chaining words, length counter
`default_nettype none
module uv3_datapath #(
	parameter int unsigned LengthBits = uv3_pkg::LengthBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire uv3_pkg::uv3_cmd_t cmd,
	input wire logic [7:0] name_byte,
	input wire logic [63:0] ns_high,
	input wire logic [63:0] ns_low,
	output uv3_pkg::uv3_status_t status,
	output uv3_pkg::out_item_t result
);
	import uv3_pkg::*;

	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [LengthBits-1:0] len_q;
	logic [5:0] step_q;
	logic [5:0] wpos_q;
	logic [7:0] name_q;
	logic [127:0] ns_w;
	logic [7:0] wbyte;
	logic msg_write;
	logic [7:0] ram_rdata [4];
	logic [31:0] m_w;
	logic [31:0] f_w, t_w, rot_w;
	logic [4:0] rot_s;
	logic [LengthBits+2:0] bitlen;
	logic [63:0] bitlen64;
	logic [7:0] dig [16];
	logic [3:0] g_next;
	logic [127:0] dig_flat;

	assign ns_w = {ns_high, ns_low};
	assign bitlen = {len_q, 3'b000};
	assign bitlen64 = 64'(bitlen);
	assign msg_write = cmd.write_byte && (cmd.byte_sel == SEL_NAME || cmd.byte_sel == SEL_NS);

	always_comb begin
		case (cmd.byte_sel)
			SEL_NAME: wbyte = name_q;
			SEL_NS: wbyte = ns_w[{~cmd.ns_idx, 3'b111} -: 8];
			// first pad byte sits right after the message
			SEL_PAD: wbyte = (wpos_q == len_q[5:0]) ? 8'h80 : 8'h00;
			SEL_LEN: wbyte = bitlen64[{wpos_q[2:0], 3'b000} +: 8];
			default: wbyte = 8'h00;
		endcase
	end

	// four byte lanes give one message word per read, addressed a step early
	assign g_next = msg_idx(cmd.round_en ? 6'(step_q + 6'd1) : 6'd0);
	for (genvar l = 0; l < 4; l++) begin : g_lane
		uv3_ram #(.Width(8), .Depth(16)) u_ram (
			.clk(clk),
			.we(cmd.write_byte && wpos_q[1:0] == 2'(l)),
			.waddr(wpos_q[5:2]),
			.wdata(wbyte),
			.raddr(g_next),
			.rdata(ram_rdata[l])
		);
	end
	assign m_w = {ram_rdata[3], ram_rdata[2], ram_rdata[1], ram_rdata[0]};

	always_comb begin
		case (step_q[5:4])
			2'd0: f_w = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_w = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f_w = b_q ^ c_q ^ d_q;
			default: f_w = c_q ^ (b_q | ~d_q);
		endcase
		rot_s = rot_amt(step_q);
		t_w = f_w + a_q + sine_k(step_q) + m_w;
		rot_w = (t_w << rot_s) | (t_w >> (6'd32 - {1'b0, rot_s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= 32'h67452301; h_q[1] <= 32'hefcdab89;
			h_q[2] <= 32'h98badcfe; h_q[3] <= 32'h10325476;
			len_q <= '0;
			wpos_q <= '0;
			step_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q[0] <= 32'h67452301; h_q[1] <= 32'hefcdab89;
				h_q[2] <= 32'h98badcfe; h_q[3] <= 32'h10325476;
				len_q <= '0;
				wpos_q <= '0;
			end else begin
				if (cmd.chain_add) begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				end
				if (msg_write) begin
					len_q <= len_q + 1'b1;
				end
				if (cmd.write_byte) begin
					wpos_q <= wpos_q + 6'd1;
				end
			end
			if (cmd.start_round) begin
				step_q <= '0;
			end else if (cmd.round_en) begin
				step_q <= step_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			name_q <= name_byte;
		end
		if (cmd.start_round) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot_w;
		end
	end

	for (genvar k = 0; k < 16; k++) begin : g_dig
		assign dig[k] = h_q[k / 4][8 * (k % 4) +: 8];
	end
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			dig_flat[127 - 8 * k -: 8] = dig[k];
		end
		dig_flat[79:72] = (dig[6] & 8'h0F) | 8'h30;
		dig_flat[63:56] = (dig[8] & 8'h3F) | 8'h80;
	end
	assign result.uuid_high = dig_flat[127:64];
	assign result.uuid_low = dig_flat[63:0];

	assign status.pos = wpos_q;
	assign status.round_last = (step_q == 6'd63);
endmodule
`default_nettype wire

[rtl/uv3_ctrl.sv]
// sequencer: byte intake, namespace load, rounds, padding, result handoff
`default_nettype none
module uv3_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire uv3_pkg::in_item_t item,
	input wire logic out_stall,
	input wire uv3_pkg::uv3_status_t status,
	output logic in_stall,
	output logic out_valid,
	output uv3_pkg::uv3_cmd_t cmd
);
	import uv3_pkg::*;

	uv3_state_t state_q, state_d;
	logic started_q, started_d;
	logic final_q, final_d;
	logic pend_byte_q, pend_last_q;
	logic [3:0] ns_cnt_q;
	logic take;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && !in_stall && (item.byte_present || item.last_item);
	assign out_valid = (state_q == ST_OUT);

	// next state
	always_comb begin
		state_d = state_q;
		started_d = started_q;
		final_d = final_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (!started_q) begin
						state_d = ST_NS;
					end else if (item.byte_present) begin
						state_d = ST_BYTE;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_NS: begin
				if (ns_cnt_q == 4'd15) begin
					started_d = 1'b1;
					state_d = pend_byte_q ? ST_BYTE : ST_PAD;
				end
			end
			ST_BYTE: begin
				if (status.pos == 6'd63) begin
					state_d = ST_LOAD;
				end else if (pend_last_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				if (status.round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pend_last_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (status.pos == 6'd63) begin
					state_d = ST_LOAD;
				end else if (status.pos == 6'd55) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (status.pos == 6'd63) begin
					final_d = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
					started_d = 1'b0;
					final_d = 1'b0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			final_q <= 1'b0;
			ns_cnt_q <= '0;
			pend_byte_q <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			started_q <= started_d;
			final_q <= final_d;
			if (take) begin
				pend_byte_q <= item.byte_present;
				pend_last_q <= item.last_item;
			end
			ns_cnt_q <= (state_q == ST_NS) ? ns_cnt_q + 4'd1 : 4'd0;
		end
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.ns_idx = ns_cnt_q;
		cmd.load_byte = take;
		case (state_q)
			ST_NS: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = SEL_NS;
			end
			ST_BYTE: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = SEL_NAME;
			end
			ST_LOAD: cmd.start_round = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_ADD: cmd.chain_add = 1'b1;
			ST_PAD: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = SEL_PAD;
			end
			ST_LEN: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = SEL_LEN;
			end
			ST_OUT: cmd.init = !out_stall;
			default: cmd.init = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/name_based_uuid_v3_generator.sv]
// uuid v3 generator: md5 over namespace and name, one round per cycle
// an item with a byte: accept, buffer write, plus load, rounds and chaining add when it fills a block
// the first item of a name also loads the 16 namespace bytes
// the last item pads, appends the bit length and compresses the final block or blocks before the result is shown
// sequential: no item is taken until the previous one is done; ignored markers are dropped while idle
// asynchronous reset loads the initial chaining words and clears length, namespace and controller state
`default_nettype none
`include "name_based_uuid_v3_generator_defines.svh"
module name_based_uuid_v3_generator #(
	parameter int unsigned LengthBits = uv3_pkg::LengthBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [uv3_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [uv3_pkg::CfgDataW-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire uv3_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output uv3_pkg::out_item_t out_data
);
	import uv3_pkg::*;

	logic [63:0] ns_high_q, ns_low_q;
	uv3_cmd_t cmd;
	uv3_status_t status;
	out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_high_q <= '0;
			ns_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NS_HIGH: ns_high_q <= cfg_data;
				REG_NS_LOW: ns_low_q <= cfg_data;
				default: ns_low_q <= ns_low_q;
			endcase
		end
	end

	uv3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .item(in_data),
		.out_stall(out_stall), .status(status), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	uv3_datapath #(.LengthBits(LengthBits)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .name_byte(in_data.name_byte),
		.ns_high(ns_high_q), .ns_low(ns_low_q),
		.status(status), .result(result)
	);
	assign out_data = result;

	`UV3_ASSERT(a_out_stall_excl, !(out_valid && !in_stall), "result shown while idle")
	`UV3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
	`UV3_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
endmodule
`default_nettype wire

[tb/uuid_v3_checker.sv]
// checker for the uuid v3 generator: md5 prediction and result comparison
`timescale 1ns / 100ps
`default_nettype none
module uuid_v3_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [uv3_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [uv3_pkg::CfgDataW-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire uv3_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire uv3_pkg::out_item_t out_data,
	output int errors,
	output int pending
);
	logic [31:0] md5_k [64];
	int md5_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic [31:0] chain [4];
	logic [7:0] blk [64];
	logic [32:0] byte_count;
	logic name_open;
	logic [63:0] ns_high, ns_low;
	uv3_pkg::out_item_t uuid_fifo [$];

	// sine constants from their definition
	initial begin
		real r;
		for (int i = 0; i < 64; i++) begin
			r = $sin(i + 1);
			if (r < 0.0) r = -r;
			md5_k[i] = 32'(longint'($floor(r * 4294967296.0)));
		end
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void md5_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g, r;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			r = i / 16;
			case (r)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			t = f + a + md5_k[i] + w[g];
			a = d; d = c; c = b;
			b = b + rotl(t, md5_s[r * 4 + i % 4]);
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endfunction

	function automatic void hash_restart();
		chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
		byte_count = '0;
		name_open = 1'b0;
	endfunction

	function automatic void absorb(input logic [7:0] v);
		logic [5:0] pos;
		pos = byte_count[5:0];
		blk[pos] = v;
		byte_count = byte_count + 33'd1;
		if (pos == 6'd63) md5_block();
	endfunction

	function automatic uv3_pkg::out_item_t finish_uuid();
		logic [63:0] bit_len;
		logic [7:0] dg [16];
		int pos;
		uv3_pkg::out_item_t res;
		bit_len = 64'(byte_count) << 3;
		pos = int'(byte_count[5:0]);
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin blk[pos] = 8'h00; pos++; end
			md5_block();
			pos = 0;
		end
		while (pos < 56) begin blk[pos] = 8'h00; pos++; end
		for (int k = 0; k < 8; k++) blk[56 + k] = bit_len[8*k +: 8];
		md5_block();
		for (int k = 0; k < 16; k++) dg[k] = chain[k / 4][8 * (k % 4) +: 8];
		dg[6] = {4'h3, dg[6][3:0]};
		dg[8] = {2'b10, dg[8][5:0]};
		for (int k = 0; k < 8; k++) begin
			res.uuid_high[63 - 8*k -: 8] = dg[k];
			res.uuid_low[63 - 8*k -: 8] = dg[8 + k];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		uv3_pkg::out_item_t exp_uuid;
		if (!arst_n) begin
			hash_restart();
			ns_high = '0;
			ns_low = '0;
			uuid_fifo.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == uv3_pkg::REG_NS_HIGH) ns_high = cfg_data;
				else if (cfg_index == uv3_pkg::REG_NS_LOW) ns_low = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (uuid_fifo.size() == 0) begin
					$error("uuid result with no transaction pending: %h %h",
						out_data.uuid_high, out_data.uuid_low);
					errors++;
				end else begin
					exp_uuid = uuid_fifo.pop_front();
					if (out_data.uuid_high !== exp_uuid.uuid_high) begin
						$error("uuid_high expected %h actual %h",
							exp_uuid.uuid_high, out_data.uuid_high);
						errors++;
					end
					if (out_data.uuid_low !== exp_uuid.uuid_low) begin
						$error("uuid_low expected %h actual %h",
							exp_uuid.uuid_low, out_data.uuid_low);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall && (in_data.byte_present || in_data.last_item)) begin
				// namespace is taken at the first useful transaction of a name
				if (!name_open) begin
					name_open = 1'b1;
					for (int k = 0; k < 8; k++) absorb(ns_high[63 - 8*k -: 8]);
					for (int k = 0; k < 8; k++) absorb(ns_low[63 - 8*k -: 8]);
				end
				if (in_data.byte_present) absorb(in_data.name_byte);
				if (in_data.last_item) begin
					uuid_fifo.push_back(finish_uuid());
					hash_restart();
				end
			end
		end
		pending = uuid_fifo.size();
	end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// top of the uuid v3 generator testbench: stimulus, idling and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int CycleLimit = 1000000;
	localparam int PhaseItems = 533;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [uv3_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [uv3_pkg::CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	uv3_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	uv3_pkg::out_item_t out_data;
	int errors, pending;
	int tx_idle_pct = 0, rx_idle_pct = 0;
	int name_items = 0, names_sent = 0, cycles = 0;

	always #4 clk = ~clk;

	name_based_uuid_v3_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	uuid_v3_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// one transaction, called and returning at a rising edge
	task automatic send_item(input logic [7:0] b, input logic present, input logic last);
		logic ok;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{name_byte: b, byte_present: present, last_item: last};
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		if (present || last) name_items++;
	endtask

	task automatic set_namespace(input logic [63:0] hi, input logic [63:0] lo);
		drain();
		// a name byte that fills a block may leave the block busy for a while
		repeat (160) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= uv3_pkg::REG_NS_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= uv3_pkg::REG_NS_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_name(input int len, input logic empty_end);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (k == len - 1) && !empty_end);
		end
		if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
		names_sent++;
	endtask

	function automatic int pick_len();
		int edge_lens [10] = '{0, 1, 39, 40, 47, 48, 55, 56, 111, 112};
		int r;
		r = $urandom_range(99);
		if (r < 30) return edge_lens[$urandom_range(9)];
		if (r < 34) return $urandom_range(100, 200);
		return $urandom_range(0, 20);
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset namespace, then directed names
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		set_namespace(64'h6ba7b8109dad11d1, 64'h80b400c04fd430c8);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h01, 1'b1, 1'b1);
		// new namespace takes effect at the next name
		drain();
		set_namespace('1, '1);
		send_item(8'haa, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			int start_items;
			case (ph)
				0: begin tx_idle_pct = 26; rx_idle_pct = 76; set_namespace('0, '0); end
				1: begin tx_idle_pct = 76; rx_idle_pct = 26; set_namespace('1, '1); end
				default: begin
					tx_idle_pct = 0; rx_idle_pct = 0;
					set_namespace({$urandom, $urandom}, {$urandom, $urandom});
				end
			endcase
			start_items = name_items;
			while (name_items - start_items < PhaseItems) begin
				send_name(pick_len(), $urandom_range(3) == 0);
				if ($urandom_range(19) == 0) drain();
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("tb_top: %0d name transactions in %0d names over three namespaces",
			name_items, names_sent);
		$display("tb_top: sender and receiver idling mixed, then back to back");
		if (errors == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

[name_based_uuid_v3_generator.f]
+incdir+rtl
rtl/uv3_pkg.sv
rtl/uv3_ram.sv
rtl/uv3_datapath.sv
rtl/uv3_ctrl.sv
rtl/name_based_uuid_v3_generator.sv
tb/uuid_v3_checker.sv
tb/tb_top.sv
